### rtl/mevd_pkg.sv
// Package for the max equal-value distance block: sizes, table entry layout and limits.
// Used by the top level and its interface definitions; depends on nothing else.
`default_nettype none

package mevd_pkg;

  // Number of table entries (one per possible value) and the longest sequence.
  localparam int VALUE_COUNT = 65536;
  localparam int MAX_LENGTH  = 65536;

  // Payload widths of the input and result items.
  localparam int VALUE_W = 16;
  localparam int DIST_W  = 16;
  localparam logic [DIST_W-1:0] BEST_MAX = '1;

  // Table address, running position (holds MAX_LENGTH itself) and stored position.
  localparam int ADDR_W  = $clog2(VALUE_COUNT);
  localparam int POS_W   = $clog2(MAX_LENGTH + 1);
  localparam int STORE_W = $clog2(MAX_LENGTH);

  // Each table entry carries a sequence tag; an entry is valid only if its tag
  // equals the current tag. Tag zero is reserved for swept entries.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;

  localparam int ENTRY_W = EPOCH_W + STORE_W;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    epoch_t             epoch;
    logic [STORE_W-1:0] first_pos;
  } entry_t;

endpackage

`default_nettype wire

### rtl/mevd_if.sv
// Channel interfaces of the max equal-value distance block: input items and result items.
// Depends on mevd_pkg for the payload types.
`default_nettype none

interface mevd_in_if;
  logic            valid;
  logic            ready;
  mevd_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mevd_out_if;
  logic            valid;
  logic            ready;
  mevd_pkg::dist_t best_distance;
  logic            overflow;

  modport source (output valid, output best_distance, output overflow, input ready);
  modport sink   (input valid, input best_distance, input overflow, output ready);
endinterface

`default_nettype wire

### rtl/mevd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; width and depth are set by the instantiating module.
`default_nettype none

module mevd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/max_equal_value_distance.sv
// Max equal-value distance: top level with the first-position table and the update stage.
// Depends on mevd_pkg, the channel interfaces in mevd_if and the RAM in mevd_ram.
//
// The block takes one value per item, with the final item of a sequence marked by last,
// and returns one result per sequence: the largest index gap between two equal values
// (0 if none repeats, saturated at 65535) and a flag set when the sequence ran longer
// than MAX_LENGTH items; items past that length are counted as overflow and ignored.
// An item is accepted every cycle unless the update stage stalls, a tag wrap is pending
// or the table is being swept: a table read is issued on acceptance and the update stage
// compares and writes back once the read data is registered, with the last write forwarded
// to a following item on the same value. The result waits in an output register, so input
// flows while a result is pending; the update stage stalls only when a last item meets
// a full output register. The per-value seen marks are tags stored with each table
// entry, so ending a sequence clears them at once. After reset, and after every 255 sequences
// when the tag wraps, the block sweeps the table and accepts no item during the sweep.
`default_nettype none

module max_equal_value_distance (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mevd_in_if.sink         in_ch,
  mevd_out_if.source      out_ch
);

  // Table port signals.
  logic                  ram_we;
  mevd_pkg::addr_t       ram_waddr;
  mevd_pkg::entry_t      ram_wdata;
  logic                  ram_re;
  mevd_pkg::addr_t       ram_raddr;
  logic [mevd_pkg::ENTRY_W-1:0] ram_rdata;

  // Sweep control.
  logic                  clear_r, clear_nxt;
  mevd_pkg::addr_t       clr_addr_r, clr_addr_nxt;

  // Update stage holding one item whose table read is in flight.
  logic                  s1_valid_r, s1_valid_nxt;
  mevd_pkg::addr_t       s1_addr_r;
  logic                  s1_inrange_r;
  logic                  s1_last_r;

  // Last table write, forwarded to the next item.
  logic                  fwd_valid_r, fwd_valid_nxt;
  mevd_pkg::addr_t       fwd_addr_r;
  mevd_pkg::entry_t      fwd_data_r;

  // Sequence state.
  mevd_pkg::pos_t        pos_r, pos_nxt;
  mevd_pkg::dist_t       best_r, best_nxt;
  logic                  ovf_r, ovf_nxt;
  mevd_pkg::epoch_t      epoch_r, epoch_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  mevd_pkg::dist_t       out_best_r;
  logic                  out_ovf_r;

  // Stage decisions.
  logic                  in_fire;
  logic                  s1_fire;
  logic                  out_free;
  logic                  wrap_hold;
  mevd_pkg::entry_t      cur_entry;
  logic                  hit;
  logic                  at_limit;
  logic [31:0]           dist_wide;
  mevd_pkg::dist_t       dist_sat;
  mevd_pkg::dist_t       best_upd;
  logic                  ovf_upd;
  logic                  s1_write;
  mevd_pkg::entry_t      s1_wdata;

  // Handshakes: a last item waits for the output register; the input stage advances
  // only when the update stage frees up, and pauses for the sweep and for a tag wrap.
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign wrap_hold = s1_valid_r && s1_last_r && (epoch_r == mevd_pkg::EPOCH_MAX);
  assign in_ch.ready = !clear_r && !wrap_hold && (!s1_valid_r || s1_fire);
  assign in_fire   = in_ch.valid && in_ch.ready;

  // Table read on acceptance.
  assign ram_re    = in_fire;
  assign ram_raddr = mevd_pkg::ADDR_W'(in_ch.value);

  // Current entry: forwarded write when it hit the same address, else the RAM data.
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur_entry = fwd_data_r;
    end else begin
      cur_entry = mevd_pkg::entry_t'(ram_rdata);
    end
  end

  assign hit      = (cur_entry.epoch == epoch_r);
  assign at_limit = (32'(pos_r) >= 32'(mevd_pkg::MAX_LENGTH));

  // Distance to the first occurrence, saturated to the result width.
  assign dist_wide = 32'(pos_r) - 32'(cur_entry.first_pos);
  assign dist_sat  = (dist_wide > 32'(mevd_pkg::BEST_MAX)) ? mevd_pkg::BEST_MAX
                                                            : mevd_pkg::DIST_W'(dist_wide);

  // Update of the sequence state for the item in the update stage.
  always_comb begin
    best_upd = best_r;
    ovf_upd  = ovf_r;
    s1_write = 1'b0;
    s1_wdata.epoch     = epoch_r;
    s1_wdata.first_pos = pos_r[mevd_pkg::STORE_W-1:0];
    if (at_limit) begin
      ovf_upd = 1'b1;
    end else if (s1_inrange_r) begin
      if (!hit) begin
        s1_write = 1'b1;
      end else if (dist_sat > best_r) begin
        best_upd = dist_sat;
      end
    end
  end

  // Next sequence state, tag and sweep control.
  always_comb begin
    pos_nxt      = pos_r;
    best_nxt     = best_r;
    ovf_nxt      = ovf_r;
    epoch_nxt    = epoch_r;
    clear_nxt    = clear_r;
    clr_addr_nxt = clr_addr_r;
    if (clear_r) begin
      clr_addr_nxt = clr_addr_r + mevd_pkg::ADDR_W'(1);
      if (32'(clr_addr_r) == 32'(mevd_pkg::VALUE_COUNT - 1)) begin
        clear_nxt = 1'b0;
      end
    end
    if (s1_fire) begin
      best_nxt = best_upd;
      ovf_nxt  = ovf_upd;
      if (!at_limit) begin
        pos_nxt = pos_r + mevd_pkg::POS_W'(1);
      end
      if (s1_last_r) begin
        pos_nxt  = '0;
        best_nxt = '0;
        ovf_nxt  = 1'b0;
        if (epoch_r == mevd_pkg::EPOCH_MAX) begin
          epoch_nxt    = mevd_pkg::EPOCH_FIRST;
          clear_nxt    = 1'b1;
          clr_addr_nxt = '0;
        end else begin
          epoch_nxt = epoch_r + mevd_pkg::EPOCH_W'(1);
        end
      end
    end
  end

  // Table write: sweep entries or record a first occurrence.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_r;
    ram_wdata = s1_wdata;
    if (clear_r) begin
      ram_we          = 1'b1;
      ram_waddr       = clr_addr_r;
      ram_wdata.epoch = mevd_pkg::EPOCH_SWEPT;
      ram_wdata.first_pos = '0;
    end else if (s1_fire && s1_write) begin
      ram_we = 1'b1;
    end
  end

  // Control next values.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    fwd_valid_nxt = fwd_valid_r;
    if (clear_r) begin
      fwd_valid_nxt = 1'b0;
    end else if (s1_fire && s1_write) begin
      fwd_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and sequence registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r     <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      pos_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      epoch_r     <= mevd_pkg::EPOCH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      clear_r     <= clear_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      pos_r       <= pos_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r    <= mevd_pkg::ADDR_W'(in_ch.value);
      s1_inrange_r <= (32'(in_ch.value) < 32'(mevd_pkg::VALUE_COUNT));
      s1_last_r    <= in_ch.last;
    end
    if (s1_fire && s1_write) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= s1_wdata;
    end
    if (s1_fire && s1_last_r) begin
      out_best_r <= best_upd;
      out_ovf_r  <= ovf_upd;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_distance = out_best_r;
  assign out_ch.overflow      = out_ovf_r;

  // First-position table with sequence tags.
  mevd_ram #(
    .WIDTH (mevd_pkg::ENTRY_W),
    .DEPTH (mevd_pkg::VALUE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
